// ===== rtl/jia_pkg.sv =====
// shared types and constants for the integer/long alu
package jia_pkg;

    localparam int XLEN      = 64;
    localparam int DIV_STEPS = 64;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_DIV  = 4'd3,
        CMD_REM  = 4'd4,
        CMD_NEG  = 4'd5,
        CMD_SHL  = 4'd6,
        CMD_SHR  = 4'd7,
        CMD_USHR = 4'd8,
        CMD_AND  = 4'd9,
        CMD_OR   = 4'd10,
        CMD_XOR  = 4'd11
    } cmd_t;

    localparam logic [4:0] INT_SHIFT_MASK  = 5'h1F;
    localparam logic [5:0] LONG_SHIFT_MASK = 6'h3F;

    typedef struct packed {
        logic [3:0]        command;
        logic              is_long;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } jia_req_t;

    typedef struct packed {
        logic signed [63:0] result;
        logic               divide_by_zero;
    } jia_rsp_t;

    // side information carried alongside the divider
    typedef struct packed {
        logic        valid;
        logic [3:0]  cmd;
        logic        is_long;
        logic        neg_a;
        logic        neg_b;
        logic        dz;
        logic [63:0] other;
    } jia_meta_t;

endpackage

// ===== rtl/jvm_integer_alu_unit.sv =====
// top level of the java int/long arithmetic and logic unit
// path: stages 1 to 3, the 64 divider stages, then the rsp output register
// throughput: one transfer per cycle while rsp is not stalled; depth is set by the 64-stage divider
// a stalled result freezes the whole pipeline, bubbles are not squeezed out
// reset clears all valid bits and the divider side information; other payload registers are not reset
module jvm_integer_alu_unit
    import jia_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  jia_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output jia_rsp_t rsp
);

    logic en;

    // stage 1: operands in, int operands sign-extended
    logic            s1_valid_reg;
    logic [3:0]      s1_cmd_reg;
    logic            s1_long_reg;
    logic [XLEN-1:0] s1_a_reg;
    logic [XLEN-1:0] s1_b_reg;

    // stage 2: simple ops, partial products, magnitudes
    logic            s2_valid_reg;
    logic [3:0]      s2_cmd_reg;
    logic            s2_long_reg;
    logic [XLEN-1:0] s2_simple_reg;
    logic [63:0]     s2_ll_reg;
    logic [31:0]     s2_lh_reg;
    logic [31:0]     s2_hl_reg;
    logic [XLEN-1:0] s2_ma_reg;
    logic [XLEN-1:0] s2_mb_reg;
    logic            s2_na_reg;
    logic            s2_nb_reg;
    logic            s2_dz_reg;

    // stage 3: product summed, handed to the divider
    jia_meta_t       s3_meta_reg;
    logic [XLEN-1:0] s3_ma_reg;
    logic [XLEN-1:0] s3_mb_reg;

    jia_meta_t       d_meta;
    logic [XLEN-1:0] d_quo;
    logic [XLEN-1:0] d_rem;

    logic            rsp_valid_reg;
    jia_rsp_t        rsp_reg;
    logic            rsp_long_reg;

    logic [XLEN-1:0] s2_simple_next;
    logic [5:0]      shamt;
    logic [XLEN-1:0] res_next;
    logic [XLEN-1:0] div_res;
    logic [XLEN-1:0] prod;

    assign en        = ~rsp_valid_reg | ~rsp_stall;
    assign req_stall = ~en;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg  <= req.command;
            s1_long_reg <= req.is_long;
            s1_a_reg    <= req.is_long ? req.operand_a
                           : {{32{req.operand_a[31]}}, req.operand_a[31:0]};
            s1_b_reg    <= req.is_long ? req.operand_b
                           : {{32{req.operand_b[31]}}, req.operand_b[31:0]};
        end
    end

    // stage 2
    always_comb
    begin
        shamt = s1_long_reg ? (s1_b_reg[5:0] & LONG_SHIFT_MASK)
                            : {1'b0, s1_b_reg[4:0] & INT_SHIFT_MASK};
        unique case (cmd_t'(s1_cmd_reg))
            CMD_ADD:  s2_simple_next = s1_a_reg + s1_b_reg;
            CMD_SUB:  s2_simple_next = s1_a_reg - s1_b_reg;
            CMD_NEG:  s2_simple_next = '0 - s1_a_reg;
            CMD_SHL:  s2_simple_next = s1_a_reg << shamt;
            CMD_SHR:  s2_simple_next = $unsigned($signed(s1_a_reg) >>> shamt);
            CMD_USHR: s2_simple_next = s1_long_reg ? (s1_a_reg >> shamt)
                                       : ({32'd0, s1_a_reg[31:0]} >> shamt);
            CMD_AND:  s2_simple_next = s1_a_reg & s1_b_reg;
            CMD_OR:   s2_simple_next = s1_a_reg | s1_b_reg;
            CMD_XOR:  s2_simple_next = s1_a_reg ^ s1_b_reg;
            default:  s2_simple_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_long_reg   <= s1_long_reg;
            s2_simple_reg <= s2_simple_next;
            s2_ll_reg     <= s1_a_reg[31:0] * s1_b_reg[31:0];
            s2_lh_reg     <= 32'(s1_a_reg[31:0] * s1_b_reg[63:32]);
            s2_hl_reg     <= 32'(s1_a_reg[63:32] * s1_b_reg[31:0]);
            s2_na_reg     <= s1_a_reg[XLEN-1];
            s2_nb_reg     <= s1_b_reg[XLEN-1];
            s2_ma_reg     <= s1_a_reg[XLEN-1] ? ('0 - s1_a_reg) : s1_a_reg;
            s2_mb_reg     <= s1_b_reg[XLEN-1] ? ('0 - s1_b_reg) : s1_b_reg;
            s2_dz_reg     <= (s1_b_reg == '0)
                             && ((s1_cmd_reg == CMD_DIV) || (s1_cmd_reg == CMD_REM));
        end
    end

    // stage 3: only the low 64 bits of the product are kept
    assign prod = s2_ll_reg + {s2_lh_reg + s2_hl_reg, 32'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_meta_reg <= '0;
        end
        else if (en)
        begin
            s3_meta_reg.valid   <= s2_valid_reg;
            s3_meta_reg.cmd     <= s2_cmd_reg;
            s3_meta_reg.is_long <= s2_long_reg;
            s3_meta_reg.neg_a   <= s2_na_reg;
            s3_meta_reg.neg_b   <= s2_nb_reg;
            s3_meta_reg.dz      <= s2_dz_reg;
            s3_meta_reg.other   <= (s2_cmd_reg == CMD_MUL) ? prod : s2_simple_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ma_reg <= s2_ma_reg;
            // zero divisor goes through as one; its result is dropped anyway
            s3_mb_reg <= s2_dz_reg ? XLEN'(1) : s2_mb_reg;
        end
    end

    jia_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .meta_in   (s3_meta_reg),
        .dividend  (s3_ma_reg),
        .divisor   (s3_mb_reg),
        .meta_out  (d_meta),
        .quotient  (d_quo),
        .remainder (d_rem)
    );

    // sign fix-up: remainder follows the dividend, quotient the sign product
    always_comb
    begin
        if (d_meta.dz)
        begin
            div_res = '0;
        end
        else if (d_meta.cmd == CMD_REM)
        begin
            div_res = d_meta.neg_a ? ('0 - d_rem) : d_rem;
        end
        else
        begin
            div_res = (d_meta.neg_a ^ d_meta.neg_b) ? ('0 - d_quo) : d_quo;
        end
        res_next = ((d_meta.cmd == CMD_DIV) || (d_meta.cmd == CMD_REM))
                   ? div_res : d_meta.other;
        if (!d_meta.is_long)
        begin
            res_next = {{32{res_next[31]}}, res_next[31:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= d_meta.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg.result         <= res_next;
            rsp_reg.divide_by_zero <= d_meta.dz;
            rsp_long_reg           <= d_meta.is_long;
        end
    end

    a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.divide_by_zero |-> rsp_reg.result == '0)
        else $error("zero divisor gave a nonzero result");

    a_int_sext : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_long_reg |-> rsp_reg.result[63:32] == {32{rsp_reg.result[31]}})
        else $error("int result not sign-extended");

    a_dz_cmd : assert property (@(posedge clk) disable iff (!rst_n)
        d_meta.valid && d_meta.dz |-> (d_meta.cmd == CMD_DIV) || (d_meta.cmd == CMD_REM))
        else $error("divide-by-zero flag on a non-divide command");

endmodule

// ===== rtl/jia_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module jia_div
    import jia_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  jia_meta_t        meta_in,
    input  logic [XLEN-1:0]  dividend,
    input  logic [XLEN-1:0]  divisor,
    output jia_meta_t        meta_out,
    output logic [XLEN-1:0]  quotient,
    output logic [XLEN-1:0]  remainder
);

    jia_meta_t       meta_reg [DIV_STEPS];
    logic [XLEN-1:0] rem_reg  [DIV_STEPS];
    logic [XLEN-1:0] quo_reg  [DIV_STEPS];
    logic [XLEN-1:0] dsr_reg  [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        jia_meta_t       meta_p;
        logic [XLEN-1:0] rem_p;
        logic [XLEN-1:0] quo_p;
        logic [XLEN-1:0] dsr_p;
        logic [XLEN:0]   trial;
        logic [XLEN:0]   diff;
        logic            ge;
        logic [XLEN-1:0] rem_next;
        logic [XLEN-1:0] quo_next;

        if (i == 0) begin : g_first
            assign meta_p = meta_in;
            assign rem_p  = '0;
            assign quo_p  = dividend;
            assign dsr_p  = divisor;
        end
        else begin : g_rest
            assign meta_p = meta_reg[i-1];
            assign rem_p  = rem_reg[i-1];
            assign quo_p  = quo_reg[i-1];
            assign dsr_p  = dsr_reg[i-1];
        end

        always_comb
        begin
            trial    = {rem_p, quo_p[XLEN-1]};
            diff     = trial - {1'b0, dsr_p};
            ge       = ~diff[XLEN];
            // partial remainder stays below the divisor, so it fits the width
            rem_next = ge ? diff[XLEN-1:0] : trial[XLEN-1:0];
            quo_next = {quo_p[XLEN-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                meta_reg[i] <= '0;
            end
            else if (en)
            begin
                meta_reg[i] <= meta_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                quo_reg[i] <= quo_next;
                dsr_reg[i] <= dsr_p;
            end
        end
    end

    assign meta_out  = meta_reg[DIV_STEPS-1];
    assign quotient  = quo_reg[DIV_STEPS-1];
    assign remainder = rem_reg[DIV_STEPS-1];

endmodule
